@@ rtl/core/dmsp_pkg.sv @@
// ============================================================================
// dmsp_pkg
// Shared widths, constants and types for the dual motor speed PID block.
// ============================================================================
package dmsp_pkg;

    // Integral accumulator width.
    localparam int SUM_W = 32;

    // Error and derived term widths.
    localparam int ERR_W = 17;
    localparam int DT_W  = ERR_W + 2;
    localparam int PM_W  = 16 + ERR_W;
    localparam int IM_W  = 16 + SUM_W;
    localparam int DM_W  = 16 + DT_W;
    localparam int ACC_W = IM_W + 2;
    localparam int Q_W   = ACC_W - 8;

    // Number of registered stages inside a lane.
    localparam int NSTG = 5;

    // Divide by three through a reciprocal; exact for dividends below 2^17.
    localparam int          DIV3_SHIFT = 18;
    localparam logic [16:0] DIV3_RECIP = 17'd87382;
    localparam int          PROD_W     = 34;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_DRIVE_LIMIT = 3'd3,
        CFG_GATE_LIMIT  = 3'd4,
        CFG_STOP_BAND   = 3'd5,
        CFG_BRAKE_DELAY = 3'd6
    } cfg_idx_e;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [14:0]        drive_limit;
        logic signed [16:0] gate_limit;
        logic [14:0]        stop_band;
        logic [15:0]        brake_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] target_left;
        logic signed [15:0] target_right;
        logic signed [15:0] encoder_left;
        logic signed [15:0] encoder_right;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic               moving;
    } out_item_t;

    // Pipeline control shared by the lanes: input transfer and stage loads.
    typedef struct packed {
        logic            accept;
        logic [NSTG-1:0] en;
    } pipe_ctrl_t;

endpackage

@@ rtl/core/dmsp_lane.sv @@
// ============================================================================
// dmsp_lane
// One motor's speed PID: state update, products, sum, clamp and brake.
// ============================================================================
module dmsp_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmsp_pkg::pipe_ctrl_t   ctrl,
    input  dmsp_pkg::cfg_t         cfg,
    input  logic signed [15:0]     target,
    input  logic signed [15:0]     encoder,
    input  logic [31:0]            now_ms,
    output logic signed [15:0]     drive
);
    import dmsp_pkg::*;

    // Controller state.
    logic signed [ERR_W-1:0] err_now_reg, err_prev_reg;
    logic signed [SUM_W-1:0] err_sum_reg;
    logic signed [15:0]      last_target_reg;
    logic [31:0]             stop_time_reg;

    logic signed [ERR_W-1:0] err_now_next;
    logic signed [SUM_W-1:0] err_sum_next;
    logic [31:0]             stop_time_next;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [DT_W-1:0]  dterm;
    logic                    gate;
    logic                    brake;
    logic                    target_zero;

    // Stage registers.
    logic signed [ERR_W-1:0] s1_err_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic signed [DT_W-1:0]  s1_dt_reg;
    logic                    s1_gate_reg, s1_brk_reg;

    logic signed [PM_W-1:0]  s2_pm_reg;
    logic signed [IM_W-1:0]  s2_im_reg;
    logic signed [DM_W-1:0]  s2_dm_reg;
    logic                    s2_gate_reg, s2_brk_reg;

    logic signed [Q_W-1:0]   s3_q_reg;
    logic                    s3_brk_reg;

    logic signed [15:0]      s4_drive_reg;
    logic                    s4_brk_reg;

    logic signed [15:0]      s5_drive_reg;
    logic [PROD_W-1:0]       s5_prod_reg;
    logic                    s5_neg_reg, s5_brk_reg;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] gated;
    logic signed [Q_W-1:0]   lim_pos, lim_neg;
    logic signed [15:0]      clamped;
    logic [15:0]             mag;
    logic [16:0]             dbl;
    logic [15:0]             third;

    // Error, saturating integral, second difference, gate and brake test.
    always_comb
    begin
        err_now_next = {target[15], target} - {encoder[15], encoder};
        sum_wide     = {err_sum_reg[SUM_W-1], err_sum_reg}
                     + {{(SUM_W+1-ERR_W){err_now_next[ERR_W-1]}}, err_now_next};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            err_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            err_sum_next = sum_wide[SUM_W-1:0];
        end
        dterm = {{2{err_now_next[ERR_W-1]}}, err_now_next}
              - {err_now_reg[ERR_W-1], err_now_reg, 1'b0}
              + {{2{err_prev_reg[ERR_W-1]}}, err_prev_reg};
        gate        = err_now_next < cfg.gate_limit;
        target_zero = target == 16'sd0;
        stop_time_next = (last_target_reg != 16'sd0 && target_zero) ? now_ms
                                                                     : stop_time_reg;
        brake = target_zero && ((now_ms - stop_time_next) > {16'd0, cfg.brake_delay_ms});
    end

    // State moves only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_now_reg     <= '0;
            err_prev_reg    <= '0;
            err_sum_reg     <= '0;
            last_target_reg <= '0;
            stop_time_reg   <= '0;
        end
        else if (ctrl.accept)
        begin
            err_prev_reg    <= err_now_reg;
            err_now_reg     <= err_now_next;
            err_sum_reg     <= err_sum_next;
            last_target_reg <= target;
            stop_time_reg   <= stop_time_next;
        end
    end

    // Stage one: operands for the products.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_err_reg  <= err_now_next;
            s1_sum_reg  <= err_sum_next;
            s1_dt_reg   <= dterm;
            s1_gate_reg <= gate;
            s1_brk_reg  <= brake;
        end
    end

    // Stage two: the three gain products.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            s2_pm_reg   <= PM_W'(cfg.gain_p * s1_err_reg);
            s2_im_reg   <= IM_W'(cfg.gain_i * s1_sum_reg);
            s2_dm_reg   <= DM_W'(cfg.gain_d * s1_dt_reg);
            s2_gate_reg <= s1_gate_reg;
            s2_brk_reg  <= s1_brk_reg;
        end
    end

    // Stage three: PID sum, then floor division by 256.
    always_comb
    begin
        gated = s2_gate_reg ? (ACC_W'(s2_im_reg) + ACC_W'(s2_dm_reg)) : '0;
        acc   = ACC_W'(s2_pm_reg) + gated;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            s3_q_reg   <= acc[ACC_W-1:8];
            s3_brk_reg <= s2_brk_reg;
        end
    end

    // Stage four: clamp to the drive limit.
    always_comb
    begin
        lim_pos = {{(Q_W-15){1'b0}}, cfg.drive_limit};
        lim_neg = -lim_pos;
        if (s3_q_reg > lim_pos)
        begin
            clamped = lim_pos[15:0];
        end
        else if (s3_q_reg < lim_neg)
        begin
            clamped = lim_neg[15:0];
        end
        else
        begin
            clamped = s3_q_reg[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            s4_drive_reg <= clamped;
            s4_brk_reg   <= s3_brk_reg;
        end
    end

    // Stage five: two thirds of the magnitude by reciprocal multiply.
    always_comb
    begin
        mag = s4_drive_reg[15] ? 16'(-s4_drive_reg) : s4_drive_reg;
        dbl = {mag, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            s5_prod_reg  <= PROD_W'(dbl) * PROD_W'(DIV3_RECIP);
            s5_neg_reg   <= s4_drive_reg[15];
            s5_drive_reg <= s4_drive_reg;
            s5_brk_reg   <= s4_brk_reg;
        end
    end

    // When braking, restore the sign, truncating toward zero; else pass the clamped drive.
    always_comb
    begin
        third = s5_prod_reg[DIV3_SHIFT+15:DIV3_SHIFT];
        if (s5_brk_reg)
        begin
            drive = s5_neg_reg ? 16'(-third) : third;
        end
        else
        begin
            drive = s5_drive_reg;
        end
    end

endmodule

@@ rtl/core/dmsp_merge.sv @@
// ============================================================================
// dmsp_merge
// Pipeline flow control, stop band check and the merged result register.
// ============================================================================
module dmsp_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [15:0]     encoder_left,
    input  logic signed [15:0]     encoder_right,
    input  logic [14:0]            stop_band,
    input  logic signed [15:0]     drive_left,
    input  logic signed [15:0]     drive_right,
    output dmsp_pkg::pipe_ctrl_t   ctrl,
    output logic                   out_valid,
    input  logic                   out_stall,
    output dmsp_pkg::out_item_t    out_data
);
    import dmsp_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] mov_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;
    logic [NSTG-1:0] en;
    logic            en_out;
    logic            accept;
    logic            moving;
    logic signed [16:0] sb_pos, sb_neg, enc_l, enc_r;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        en_out       = !out_valid_reg || !out_stall;
        en[NSTG-1]   = !vld_reg[NSTG-1] || en_out;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        accept      = in_valid && en[0];
        ctrl.accept = accept;
        ctrl.en     = en;
    end

    assign in_stall = !en[0];

    // Moving unless both encoders lie strictly inside the stop band.
    always_comb
    begin
        sb_pos = {2'b00, stop_band};
        sb_neg = -sb_pos;
        enc_l  = {encoder_left[15], encoder_left};
        enc_r  = {encoder_right[15], encoder_right};
        moving = !((enc_l < sb_pos) && (enc_l > sb_neg)
                && (enc_r < sb_pos) && (enc_r > sb_neg));
    end

    // Valid bits per stage and at the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= accept;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en_out)
            begin
                out_valid_reg <= vld_reg[NSTG-1];
            end
        end
    end

    // Moving flag follows the lanes, then the result register merges all.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mov_reg[0] <= moving;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (en[k])
            begin
                mov_reg[k] <= mov_reg[k-1];
            end
        end
        if (en_out)
        begin
            out_data_reg.drive_left  <= drive_left;
            out_data_reg.drive_right <= drive_right;
            out_data_reg.moving      <= mov_reg[NSTG-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/dual_motor_speed_pid.sv @@
// ============================================================================
// dual_motor_speed_pid
// Speed PID controller for a left and a right motor with brake and stop flag.
// ============================================================================
// Each input transfer carries both motors' targets, encoder counts and a
// millisecond time; two identical lanes run the left and right controllers
// side by side and a merge stage joins their drives with the moving flag. The
// first lane stage loads on the input transfer edge itself; the item then moves
// through the remaining lane stages and the output register to out_valid. A new
// item is taken every cycle unless out_stall holds a full pipeline: the lanes are
// five register stages deep (gain products in the second, the two-thirds brake
// reciprocal multiply in the fifth) followed by the output register, and each
// stage holds only when the one after it is full and held. Controller state
// updates on the input transfer itself, so consecutive items see each other's
// history. No clearing pass after reset.
module dual_motor_speed_pid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dmsp_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dmsp_pkg::out_item_t   out_data,
    input  logic                  wr_en,
    input  logic [2:0]            wr_index,
    input  logic [16:0]           wr_data
);
    import dmsp_pkg::*;

    cfg_t               cfg_reg;
    pipe_ctrl_t         ctrl;
    logic signed [15:0] drive_left, drive_right;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= 16'sd256;
            cfg_reg.gain_i         <= 16'sd0;
            cfg_reg.gain_d         <= 16'sd0;
            cfg_reg.drive_limit    <= 15'd1000;
            cfg_reg.gate_limit     <= 17'sd100;
            cfg_reg.stop_band      <= 15'd2;
            cfg_reg.brake_delay_ms <= 16'd3000;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_GAIN_P:      cfg_reg.gain_p         <= wr_data[15:0];
                CFG_GAIN_I:      cfg_reg.gain_i         <= wr_data[15:0];
                CFG_GAIN_D:      cfg_reg.gain_d         <= wr_data[15:0];
                CFG_DRIVE_LIMIT: cfg_reg.drive_limit    <= wr_data[14:0];
                CFG_GATE_LIMIT:  cfg_reg.gate_limit     <= wr_data;
                CFG_STOP_BAND:   cfg_reg.stop_band      <= wr_data[14:0];
                CFG_BRAKE_DELAY: cfg_reg.brake_delay_ms <= wr_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Left motor lane.
    dmsp_lane u_lane_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .target  (in_data.target_left),
        .encoder (in_data.encoder_left),
        .now_ms  (in_data.now_ms),
        .drive   (drive_left)
    );

    // Right motor lane.
    dmsp_lane u_lane_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .target  (in_data.target_right),
        .encoder (in_data.encoder_right),
        .now_ms  (in_data.now_ms),
        .drive   (drive_right)
    );

    // Flow control and result merge.
    dmsp_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .encoder_left  (in_data.encoder_left),
        .encoder_right (in_data.encoder_right),
        .stop_band     (cfg_reg.stop_band),
        .drive_left    (drive_left),
        .drive_right   (drive_right),
        .ctrl          (ctrl),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

@@ verif/tb_dual_motor_speed_pid.sv @@
// ============================================================================
// tb_dual_motor_speed_pid
// Self-checking testbench for the dual motor speed PID controller.
// ============================================================================
// A scoreboard class holds a bit-accurate predictor of both motor lanes,
// along with its own copy of the registers, and queues one expected drive
// result per accepted command. Each output transfer is checked field by field
// against the oldest expectation. The stimulus has four parts:
// - A directed run covers field extremes, the stop band, the gate edge,
//   braking and time wrap.
// - Several register settings, the extremes among them, each carry random
//   commands.
// - Random bursts of idling appear on both sides.
// - A final calm run drives both integrals hard one way, then the other.
// ============================================================================
module tb_dual_motor_speed_pid;

    import dmsp_pkg::*;

    // Write index that maps to no register; the block must ignore it.
    localparam logic [2:0] REG_NONE = 3'd7;

    // Cycles to let the pipeline settle once nothing is expected.
    localparam int SETTLE_CYCLES = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each drive result and checks what the block sends.
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        cfg_t               regs;
        logic signed [16:0] err0 [2];
        logic signed [16:0] err1 [2];
        logic signed [16:0] err2 [2];
        longint             integ [2];
        logic signed [15:0] prior_target [2];
        logic [31:0]        stop_ms [2];
        out_item_t          expected_drives [$];
        int unsigned        mismatches;

        function new();
            regs.gain_p         = 16'sd256;
            regs.gain_i         = 16'sd0;
            regs.gain_d         = 16'sd0;
            regs.drive_limit    = 15'd1000;
            regs.gate_limit     = 17'sd100;
            regs.stop_band      = 15'd2;
            regs.brake_delay_ms = 16'd3000;
            for (int m = 0; m < 2; m++)
            begin
                err0[m]         = '0;
                err1[m]         = '0;
                err2[m]         = '0;
                integ[m]        = 0;
                prior_target[m] = '0;
                stop_ms[m]      = '0;
            end
            mismatches = 0;
        endfunction

        // Mirror one register write; unknown indexes leave everything alone.
        function void write_reg(logic [2:0] idx, logic [16:0] d);
            case (idx)
                CFG_GAIN_P:      regs.gain_p         = d[15:0];
                CFG_GAIN_I:      regs.gain_i         = d[15:0];
                CFG_GAIN_D:      regs.gain_d         = d[15:0];
                CFG_DRIVE_LIMIT: regs.drive_limit    = d[14:0];
                CFG_GATE_LIMIT:  regs.gate_limit     = d;
                CFG_STOP_BAND:   regs.stop_band      = d[14:0];
                CFG_BRAKE_DELAY: regs.brake_delay_ms = d[15:0];
                default:         ;
            endcase
        endfunction

        // One control period of one motor lane; returns the final drive.
        function longint lane_drive(int m, longint tgt, longint enc, logic [31:0] t);
            longint      smax;
            longint      smin;
            longint      e;
            longint      acc;
            longint      drv;
            longint      lim;
            longint      gate_at;
            logic [31:0] elapsed;

            smax = (longint'(1) <<< (SUM_W - 1)) - 1;
            smin = -smax - 1;

            // Shift the error history and take the new error.
            err2[m] = err1[m];
            err1[m] = err0[m];
            e       = tgt - enc;
            err0[m] = e[16:0];

            // The integral saturates at the accumulator range.
            integ[m] = integ[m] + e;
            if (integ[m] > smax)
                integ[m] = smax;
            if (integ[m] < smin)
                integ[m] = smin;

            // The integral and derivative terms count only below the gate.
            gate_at = $signed(regs.gate_limit);
            acc     = longint'($signed(regs.gain_p)) * e;
            if (e < gate_at)
            begin
                acc += longint'($signed(regs.gain_i)) * integ[m];
                acc += longint'($signed(regs.gain_d)) *
                       (e - 2 * longint'(err1[m]) + longint'(err2[m]));
            end

            // Drop the Q8.8 fraction (floor), then clamp the magnitude.
            drv = acc >>> 8;
            lim = longint'(regs.drive_limit);
            if (drv > lim)
                drv = lim;
            if (drv < -lim)
                drv = -lim;

            // A fall of the target to zero starts the brake timer.
            if (prior_target[m] != 0 && tgt == 0)
                stop_ms[m] = t;
            elapsed = t - stop_ms[m];
            if (tgt == 0 && elapsed > regs.brake_delay_ms)
                drv = drv * 2 / 3;
            prior_target[m] = tgt[15:0];
            return drv;
        endfunction

        // Note an accepted command and queue the drive result it causes.
        function void note_command(in_item_t c);
            out_item_t want;
            longint    dl;
            longint    dr;
            longint    el;
            longint    er;
            longint    band;

            el   = $signed(c.encoder_left);
            er   = $signed(c.encoder_right);
            band = regs.stop_band;
            dl   = lane_drive(0, $signed(c.target_left), el, c.now_ms);
            dr   = lane_drive(1, $signed(c.target_right), er, c.now_ms);
            want.drive_left  = dl[15:0];
            want.drive_right = dr[15:0];
            want.moving      = !((el < band && el > -band) && (er < band && er > -band));
            expected_drives.push_back(want);
        endfunction

        // Compare one drive transfer with the oldest expectation.
        function void check_drive(out_item_t got);
            out_item_t want;

            if (expected_drives.size() == 0)
            begin
                $error("drive transfer with no command pending: left %0d right %0d",
                       got.drive_left, got.drive_right);
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            if (got.drive_left !== want.drive_left)
            begin
                $error("drive_left expected %0d actual %0d", want.drive_left, got.drive_left);
                mismatches++;
            end
            if (got.drive_right !== want.drive_right)
            begin
                $error("drive_right expected %0d actual %0d",
                       want.drive_right, got.drive_right);
                mismatches++;
            end
            if (got.moving !== want.moving)
            begin
                $error("moving expected %0d actual %0d", want.moving, got.moving);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       wr_en     = 1'b0;
    logic [2:0] wr_index  = '0;
    logic [16:0] wr_data  = '0;

    drive_scoreboard sb = new();

    // Stimulus state: quiet mode, simulated time and the last targets sent.
    bit                 calm = 1'b0;
    logic [31:0]        clock_ms = '0;
    logic signed [15:0] sent_left = '0;
    logic signed [15:0] sent_right = '0;
    int                 stall_left = 0;

    dual_motor_speed_pid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #5 clk = ~clk;

    // Watch both channels; a command is noted before a result is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_command(in_data);
            if (out_valid && !out_stall)
                sb.check_drive(out_data);
        end
    end

    // The result side stalls in random bursts; calm mode starts none.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks and stimulus helpers.
    // ------------------------------------------------------------------------

    // Present one command, after an optional idle burst, until its transfer.
    task automatic send_item(input in_item_t c);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_fields(input int tl, input int tr, input int el, input int er,
                               input logic [31:0] t);
        in_item_t c;
        c.target_left   = tl[15:0];
        c.target_right  = tr[15:0];
        c.encoder_left  = el[15:0];
        c.encoder_right = er[15:0];
        c.now_ms        = t;
        send_item(c);
    endtask

    // Stop sending and wait until every expected result has come back or the wait limit runs out.
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.expected_drives.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the write enable stays up for a following write.
    task automatic put_reg(input logic [2:0] idx, input int value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[16:0];
        @(posedge clk);
        sb.write_reg(idx, value[16:0]);
    endtask

    // Load a full register setting, plus a write to an unused index.
    task automatic program_regs(input int gp, input int gi, input int gd, input int dl,
                                input int gate, input int band, input int delay);
        put_reg(CFG_GAIN_P, gp);
        put_reg(CFG_GAIN_I, gi);
        put_reg(CFG_GAIN_D, gd);
        put_reg(CFG_DRIVE_LIMIT, dl);
        put_reg(CFG_GATE_LIMIT, gate);
        put_reg(CFG_STOP_BAND, band);
        put_reg(CFG_BRAKE_DELAY, delay);
        put_reg(REG_NONE, $urandom);
        wr_en <= 1'b0;
    endtask

    // A zero target tends to stay zero so that braking gets reached.
    function automatic logic signed [15:0] pick_target(input logic signed [15:0] prev);
        if (prev == 0 && $urandom_range(0, 3) != 0)
            return '0;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    // Encoders mostly track the target, with stop-band values and extremes.
    function automatic logic signed [15:0] pick_encoder(input logic signed [15:0] tgt);
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 6) - 3);
            2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'(int'(tgt) + $urandom_range(0, 300) - 150);
        endcase
    endfunction

    function automatic in_item_t next_command();
        in_item_t c;
        c.target_left   = pick_target(sent_left);
        c.target_right  = pick_target(sent_right);
        c.encoder_left  = pick_encoder(c.target_left);
        c.encoder_right = pick_encoder(c.target_right);
        sent_left       = c.target_left;
        sent_right      = c.target_right;

        // Time mostly creeps forward, sometimes leaps or lands anywhere.
        case ($urandom_range(0, 15))
            0:       clock_ms = $urandom;
            1:       clock_ms = clock_ms + $urandom_range(0, 70000);
            default: clock_ms = clock_ms + $urandom_range(0, 20);
        endcase
        c.now_ms = clock_ms;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands under the reset register values.
        send_fields(0, 0, 0, 0, 32'd0);
        send_fields(32767, -32768, -32768, 32767, 32'd10);
        send_fields(1, -1, 1, -1, 32'd20);
        send_fields(5, 5, 2, -2, 32'd30);
        send_fields(99, 100, 0, 0, 32'd40);
        send_fields(1000, -1000, 0, 0, 32'd45);
        send_fields(1001, -1001, 0, 0, 32'd46);
        send_fields(50, 50, 0, 0, 32'd1000);
        send_fields(0, 0, 5, -7, 32'd1000);
        send_fields(0, 0, 5, -7, 32'd4000);
        send_fields(0, 0, 5, -7, 32'd4001);
        send_fields(0, 0, -32768, 32767, 32'd100000);
        send_fields(300, -300, 0, 0, 32'hFFFF_FF00);
        send_fields(0, 0, 1, 1, 32'hFFFF_FF00);
        send_fields(0, 0, 1, 1, 32'h0000_0B00);
        send_fields(0, 0, -1, -1, 32'hFFFF_FFFF);
        send_fields(32767, 32767, 32767, 32767, 32'h8000_0000);
        send_fields(-32768, -32768, -32768, -32768, 32'h7FFF_FFFF);
        send_fields(-2, 2, 2, -2, 32'h5555_AAAA);
        send_fields(0, 0, 0, 0, 32'hAAAA_5555);
        drain();

        // Random commands under a series of register settings.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: program_regs(32767, -32768, 32767, 32767, 65535, 32767, 0);
                1: program_regs(-32768, 32767, -32768, 0, -65536, 0, 65535);
                2: program_regs(512, 16, 128, 2000, 200, 3, 50);
                3: program_regs(-300, -5, 77, 500, 0, 1, 0);
                default: program_regs($urandom_range(0, 65535) - 32768,
                                      $urandom_range(0, 65535) - 32768,
                                      $urandom_range(0, 65535) - 32768,
                                      $urandom_range(0, 32767),
                                      $urandom_range(0, 131071) - 65536,
                                      $urandom_range(0, 32767),
                                      $urandom_range(0, 65535));
            endcase
            calm = (phase == 2);
            repeat (85) send_item(next_command());
            drain();
        end

        // Calm final run: push both integrals hard one way, then the other way.
        calm = 1'b1;
        program_regs(0, 256, 0, 32767, 65535, 2, 65535);
        repeat (40)
        begin
            clock_ms = clock_ms + 10;
            send_fields(32767, -32768, -32767, 32767, clock_ms);
        end
        repeat (60)
        begin
            clock_ms = clock_ms + 10;
            send_fields(-32768, 32767, 32767, -32767, clock_ms);
        end
        drain();

        if (sb.expected_drives.size() != 0)
        begin
            $error("%0d drive results never arrived", sb.expected_drives.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a block that hangs.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
